@@ design/cle_pkg.sv @@
// Shared types and constants for the console line editor.
// Used by cle_line_store, cle_ctrl and console_line_editor; no dependencies.
`default_nettype none

package cle_pkg;

  // Line store geometry
  localparam int LINE_DEPTH = 32;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Terminal control codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_DEL = 8'h7f;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ECHO,
    KIND_LINE,
    KIND_END,
    KIND_DOWN,
    KIND_UP
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_NL,
    S_RD,
    S_LINE,
    S_CANCEL,
    S_END
  } state_t;

  // Line store access request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ design/cle_line_store.sv @@
// Line store: LINE_DEPTH bytes, one write port, one registered read port.
// Depends on cle_pkg for geometry and the request struct.
`default_nettype none

module cle_line_store
  import cle_pkg::*;
(
  input  wire logic       clk,
  input  wire mem_req_t   req,
  output logic [7:0]      rd_data
);

  logic [7:0] mem_r [LINE_DEPTH];
  logic [7:0] rd_data_r;

  // Write the stored byte
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // Read one entry a cycle into the output register
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/cle_ctrl.sv @@
// Sequencer for the console line editor: decodes a request byte, keeps the
// fill count and escape flag, and walks results out. Depends on cle_pkg.
`default_nettype none

module cle_ctrl
  import cle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic [2:0]            out_kind,
  output logic [5:0]            out_line_length,
  output logic                  out_last,
  output mem_req_t              mem_req,
  input  wire logic [7:0]       mem_rd_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [5:0]       out_len_r, out_len_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  logic             in_acc;
  logic [CNT_W-1:0] idx_inc;
  logic             walk_done;

  // Shared step unit: advance the walk index and compare with the length
  assign idx_inc   = idx_r + 1'b1;
  assign walk_done = (idx_inc == len_r);

  // Output slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign in_acc    = in_valid && !in_stall;

  // Next state and result generation
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    esc_nxt       = esc_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = fill_r[ADDR_W-1:0];
    mem_req.wdata = in_rx_byte;
    mem_req.raddr = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_rx_byte) inside
            CH_NUL: begin
            end
            CH_CR, CH_LF: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = CH_CR;
              out_kind_nxt  = KIND_ECHO;
              out_len_nxt   = '0;
              out_last_nxt  = 1'b0;
              len_nxt       = fill_r;
              idx_nxt       = '0;
              fill_nxt      = '0;
              state_nxt     = S_NL;
            end
            CH_ETX: begin
              if (fill_r != '0) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = CH_DEL;
                out_kind_nxt  = KIND_ECHO;
                out_len_nxt   = '0;
                out_last_nxt  = (fill_r == CNT_W'(1));
                len_nxt       = fill_r;
                idx_nxt       = CNT_W'(1);
                fill_nxt      = '0;
                if (fill_r != CNT_W'(1)) begin
                  state_nxt = S_CANCEL;
                end
              end
            end
            CH_BS, CH_DEL: begin
              if (fill_r != '0) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = CH_DEL;
                out_kind_nxt  = KIND_ECHO;
                out_len_nxt   = '0;
                out_last_nxt  = 1'b1;
                fill_nxt      = fill_r - 1'b1;
              end
            end
            CH_EOT: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_kind_nxt  = KIND_DOWN;
              out_len_nxt   = '0;
              out_last_nxt  = 1'b1;
            end
            CH_TAB: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_kind_nxt  = KIND_UP;
              out_len_nxt   = '0;
              out_last_nxt  = 1'b1;
            end
            CH_ESC, CH_LBR: begin
              esc_nxt = 1'b1;
            end
            default: begin
              if (esc_r) begin
                // swallow the byte after an escape
                esc_nxt = 1'b0;
              end else if (fill_r < CNT_W'(LINE_DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = in_rx_byte;
                out_kind_nxt  = KIND_ECHO;
                out_len_nxt   = '0;
                out_last_nxt  = 1'b1;
                mem_req.we    = 1'b1;
                fill_nxt      = fill_r + 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = CH_BEL;
                out_kind_nxt  = KIND_ECHO;
                out_len_nxt   = '0;
                out_last_nxt  = 1'b1;
              end
            end
          endcase
        end
      end
      S_NL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = CH_LF;
          out_kind_nxt  = KIND_ECHO;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b0;
          state_nxt     = (len_r == '0) ? S_END : S_RD;
        end
      end
      S_RD: begin
        // read data shows up next cycle
        state_nxt = S_LINE;
      end
      S_LINE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = mem_rd_data;
          out_kind_nxt  = KIND_LINE;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_inc;
          state_nxt     = walk_done ? S_END : S_RD;
        end
      end
      S_CANCEL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = CH_DEL;
          out_kind_nxt  = KIND_ECHO;
          out_len_nxt   = '0;
          out_last_nxt  = walk_done;
          idx_nxt       = idx_inc;
          if (walk_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_kind_nxt  = KIND_END;
          out_len_nxt   = 6'(len_r);
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_kind        = out_kind_r;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(LINE_DEPTH))
    else $error("fill count beyond line depth");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_END)) |-> out_last_r)
    else $error("line end not marked last");

  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ((in_rx_byte == CH_CR) || (in_rx_byte == CH_LF))) |=> (fill_r == '0))
    else $error("line end did not clear fill count");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LINE) || (state_r == S_RD)) |-> (idx_r < len_r))
    else $error("line walk past stored length");
`endif

endmodule

`default_nettype wire

@@ design/console_line_editor.sv @@
// Console line editor top level. Latency: the first result of a request is
// valid in the cycle after the request is accepted. Throughput: one result per
// cycle while the output is not stalled, but each line byte also needs an S_RD
// state first (registered line store read); a line or cancel holds off the next
// request until its last result is issued, as do output stalls. Reset (rst_n low,
// synchronous) clears fill count, escape flag, state and valid; store has no reset.
`default_nettype none

module console_line_editor
  import cle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic [5:0]      out_line_length,
  output logic            out_last
);

  mem_req_t   mem_req;
  logic [7:0] mem_rd_data;

  // Sequencer
  cle_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_line_length (out_line_length),
    .out_last        (out_last),
    .mem_req         (mem_req),
    .mem_rd_data     (mem_rd_data)
  );

  // Line store
  cle_line_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for console_line_editor: directed and random keystrokes.
// Predicts echo, line and event results in-bench; depends on cle_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import cle_pkg::*;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic [5:0] length;
    logic       last;
  } result_t;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_TOGGLE, STALL_HEAVY} stall_mode_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] in_rx_byte  = 8'h00;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic [5:0] out_line_length;
  logic       out_last;

  // Expected results, oldest first
  result_t awaited_results[$];
  result_t oldest;

  // Shadow copy of the editor state
  logic [7:0]  line_copy [LINE_DEPTH];
  int unsigned line_fill    = 0;
  logic        escape_armed = 1'b0;

  int unsigned err_count     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned lines_done    = 0;
  int unsigned bells_rung    = 0;
  int unsigned burst_left    = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  console_line_editor uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append one expected result; the last flag is fixed up per keystroke
  function automatic void queue_result(logic [7:0] data, kind_t kind, logic [5:0] length);
    result_t r;
    r.data   = data;
    r.kind   = kind;
    r.length = length;
    r.last   = 1'b0;
    awaited_results.push_back(r);
  endfunction

  // Work out the results of one accepted keystroke and advance the shadow state
  function automatic void predict_keystroke(logic [7:0] b);
    int unsigned first;
    result_t     r;
    first = awaited_results.size();
    case (b)
      CH_NUL: ;
      CH_CR, CH_LF: begin
        queue_result(CH_CR, KIND_ECHO, 6'd0);
        queue_result(CH_LF, KIND_ECHO, 6'd0);
        for (int i = 0; i < line_fill; i++) queue_result(line_copy[i], KIND_LINE, 6'd0);
        queue_result(8'h00, KIND_END, 6'(line_fill));
        line_fill = 0;
        lines_done++;
      end
      CH_ETX: begin
        for (int i = 0; i < line_fill; i++) queue_result(CH_DEL, KIND_ECHO, 6'd0);
        line_fill = 0;
      end
      CH_BS, CH_DEL: begin
        if (line_fill != 0) begin
          line_fill--;
          queue_result(CH_DEL, KIND_ECHO, 6'd0);
        end
      end
      CH_EOT: queue_result(8'h00, KIND_DOWN, 6'd0);
      CH_TAB: queue_result(8'h00, KIND_UP, 6'd0);
      CH_ESC, CH_LBR: escape_armed = 1'b1;
      default: begin
        if (escape_armed) begin
          escape_armed = 1'b0;
        end else if (line_fill < LINE_DEPTH) begin
          queue_result(b, KIND_ECHO, 6'd0);
          line_copy[line_fill] = b;
          line_fill++;
        end else begin
          queue_result(CH_BEL, KIND_ECHO, 6'd0);
          bells_rung++;
        end
      end
    endcase
    // Mark the final result of this keystroke
    if (awaited_results.size() > first) begin
      r = awaited_results.pop_back();
      r.last = 1'b1;
      awaited_results.push_back(r);
    end
  endfunction

  // Send one keystroke request; sender works in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_keystroke(b);
    if (b != CH_NUL) bytes_sent++;
  endtask

  // Draw an ordinary byte: no editing, event or escape code, never null
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    forever begin
      b = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7e)) : 8'($urandom_range(1, 255));
      case (b)
        CH_ETX, CH_EOT, CH_BS, CH_TAB, CH_LF, CH_CR, CH_ESC, CH_LBR, CH_DEL: ;
        default: return b;
      endcase
    end
  endfunction

  // Compare one field and report a mismatch
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Receiver stall pattern: switch to a random mode after a random run
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%0h length %0d last %0b",
               out_kind, out_byte, out_line_length, out_last);
        err_count++;
      end else begin
        oldest = awaited_results.pop_front();
        check_field("out_byte", oldest.data, out_byte);
        check_field("out_kind", oldest.kind, out_kind);
        check_field("out_line_length", oldest.length, out_line_length);
        check_field("out_last", oldest.last, out_last);
      end
    end
  end

  // Store, erase past the start, and ignore null
  task automatic test_basic_editing();
    send_byte(8'h61);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte(CH_NUL);
  endtask

  // Deliver a short line, then an empty one
  task automatic test_line_delivery();
    send_byte(8'h68);
    send_byte(8'h80);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Cancel a stored line, then cancel an empty one
  task automatic test_cancel();
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(CH_ETX);
    send_byte(CH_ETX);
  endtask

  task automatic test_debug_events();
    send_byte(CH_EOT);
    send_byte(CH_TAB);
  endtask

  // Escape swallows one ordinary byte and survives a line end
  task automatic test_escape();
    send_byte(CH_ESC);
    send_byte(8'h41);
    send_byte(CH_LBR);
    send_byte(8'h42);
    send_byte(8'h43);
    send_byte(CH_ESC);
    send_byte(CH_CR);
    send_byte(8'h44);
  endtask

  // Mostly well-formed lines with random content; the rest escapes, events and noise
  task automatic test_random_traffic();
    int unsigned len;
    int unsigned pick;
    bit          overfill_done;
    overfill_done = 1'b0;
    while (bytes_sent < 260) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5 || !overfill_done) begin
        // Build a line; now and then run past the store to ring the bell
        if (!overfill_done || $urandom_range(0, 9) == 0)
          len = $urandom_range(LINE_DEPTH, LINE_DEPTH + 3);
        else
          len = $urandom_range(0, 8);
        overfill_done = 1'b1;
        for (int i = 0; i < len; i++) begin
          send_byte(pick_plain());
          if ($urandom_range(0, 7) == 0) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
        end
        case ($urandom_range(0, 9))
          0, 1:    send_byte(CH_ETX);
          2:       ;
          default: send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        endcase
      end else if (pick == 6) begin
        send_byte($urandom_range(0, 1) ? CH_ESC : CH_LBR);
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 7) begin
        send_byte($urandom_range(0, 1) ? CH_EOT : CH_TAB);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    // Flush whatever is still stored
    send_byte(CH_CR);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_editing();
    test_line_delivery();
    test_cancel();
    test_debug_events();
    test_escape();
    test_random_traffic();

    // Drain outstanding results, then hold a while for strays
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d keystrokes: %0d lines delivered, %0d bells, %0d results checked.",
             bytes_sent, lines_done, bells_rung, results_seen);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
